// File: rtl/double_ended_queue_macros.svh
// assertion macros shared by the deque rtl
// no dependencies
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// implication checked on every clock edge outside reset
`define DEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque assertion failed");

// next-cycle implication checked outside reset
`define DEQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque assertion failed");

`endif

// File: rtl/deq_pkg.sv
// deque package: request kinds, status codes, controller command/status structs
// no dependencies
`timescale 1ns / 1ps
package deq_pkg;

	localparam int KIND_W = 4;
	localparam int STATUS_W = 2;
	localparam int VALUE_W = 64;
	localparam int POS_W = 6;
	localparam int COUNT_W = 7;

	typedef enum logic [KIND_W-1:0] {
		K_PUSH_HEAD = 4'd0,
		K_PUSH_TAIL = 4'd1,
		K_POP_HEAD  = 4'd2,
		K_POP_TAIL  = 4'd3,
		K_PEEK_HEAD = 4'd4,
		K_PEEK_TAIL = 4'd5,
		K_PEEK_NTH  = 4'd6,
		K_REM_FIRST = 4'd7,
		K_REM_ALL   = 4'd8,
		K_CLEAR     = 4'd9
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the request
		logic start;     // decode the request, issue the memory read
		logic finish;    // read data back, form result, update pointers
		logic walk_rd;   // issue read of the next entry during a remove
		logic walk_wr;   // take the read data, compact
		logic walk_end;  // finish a remove
		logic out_load;  // load the output register
	} deq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_remove;
		logic walk_more;
	} deq_stat_t;

endpackage

// File: rtl/deq_if.sv
// valid/ready channel interfaces for requests and results
// depends on deq_pkg
`timescale 1ns / 1ps
interface deq_req_if;
	logic valid;
	logic ready;
	logic [deq_pkg::KIND_W-1:0] kind;
	logic [deq_pkg::VALUE_W-1:0] value;
	logic [deq_pkg::POS_W-1:0] position;
	modport source (output valid, kind, value, position, input ready);
	modport sink (input valid, kind, value, position, output ready);
endinterface

interface deq_rsp_if;
	logic valid;
	logic ready;
	logic [deq_pkg::STATUS_W-1:0] status;
	logic [deq_pkg::VALUE_W-1:0] data_out;
	logic [deq_pkg::COUNT_W-1:0] removed_count;
	logic [deq_pkg::COUNT_W-1:0] fill_level;
	modport source (output valid, status, data_out, removed_count, fill_level, input ready);
	modport sink (input valid, status, data_out, removed_count, fill_level, output ready);
endinterface

// File: rtl/deq_ctrl.sv
// deque controller: one-hot sequencer for request, remove walk and result handoff
// depends on deq_pkg and the macros header
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"
module deq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  deq_pkg::deq_stat_t  stat,
	output deq_pkg::deq_cmd_t   cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_START = 5'b00010,
		S_FIN   = 5'b00100,
		S_WALK  = 5'b01000,
		S_WEND  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	// output register frees when empty or taken this cycle
	assign out_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = S_START;
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d = stat.is_remove ? S_WALK : S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				// each cycle consumes the previous read and issues the next while entries remain
				cmd.walk_wr = 1'b1;
				cmd.walk_rd = stat.walk_more;
				if (!stat.walk_more) state_d = S_WEND;
			end
			S_WEND: begin
				if (out_free) begin
					cmd.walk_end = 1'b1;
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	`DEQ_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`DEQ_ASSERT_IMP(a_load_free, clk, arst_n, cmd.out_load, out_free)
	`DEQ_ASSERT_NXT(a_cap_start, clk, arst_n, cmd.capture, state_q == S_START)
	`DEQ_ASSERT_NXT(a_load_valid, clk, arst_n, cmd.out_load, out_valid_q)

endmodule

// File: rtl/deq_dp.sv
// deque datapath: ring store, head pointer, count, remove compaction, result register
// depends on deq_pkg and the macros header
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"
module deq_dp #(
	parameter int DEPTH = 64,
	parameter int DATA_WIDTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  deq_pkg::deq_cmd_t                   cmd,
	output deq_pkg::deq_stat_t                  stat,
	input  logic [deq_pkg::KIND_W-1:0]          kind,
	input  logic [deq_pkg::VALUE_W-1:0]         value,
	input  logic [deq_pkg::POS_W-1:0]           position,
	output logic [deq_pkg::STATUS_W-1:0]        status,
	output logic [deq_pkg::VALUE_W-1:0]         data_out,
	output logic [deq_pkg::COUNT_W-1:0]         removed_count,
	output logic [deq_pkg::COUNT_W-1:0]         fill_level
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = deq_pkg::POS_W;
	localparam int OW = deq_pkg::COUNT_W;
	localparam int XW = (CW > PW) ? CW : PW;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [deq_pkg::KIND_W-1:0] kind_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [PW-1:0] pos_q;

	// walk state for removes
	logic [CW-1:0] rd_q, wr_q, rem_q;
	logic pend_q;

	logic [deq_pkg::STATUS_W-1:0] st_q;
	logic [deq_pkg::VALUE_W-1:0] dat_q;
	logic [OW-1:0] remc_q, fill_q;
	logic [deq_pkg::STATUS_W-1:0] st_pre_q;

	logic empty, full, is_rem;
	logic [AW-1:0] rd_addr, wr_addr, head_m1, head_p1;
	logic rd_en, wr_en;
	logic [DATA_WIDTH-1:0] wr_data;
	logic take, match;
	logic [deq_pkg::STATUS_W-1:0] st_start, res_st;
	logic [deq_pkg::VALUE_W-1:0] res_dat;
	logic [OW-1:0] res_remc, res_fill;

	// ring slot of head plus offset, offset below DEPTH
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [AW:0] s;
		s = {1'b0, h} + (AW+1)'(i);
		if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	assign empty = (count_q == '0);
	assign full = (count_q == CW'(DEPTH));
	assign is_rem = (kind_q == deq_pkg::K_REM_FIRST) || (kind_q == deq_pkg::K_REM_ALL);
	assign head_m1 = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_p1 = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	assign stat.is_remove = is_rem;
	assign stat.walk_more = (rd_q < count_q);

	assign match = (rdata_q == val_q);
	assign take = pend_q && match &&
		!((kind_q == deq_pkg::K_REM_FIRST) && (rem_q != '0));

	always_comb begin
		rd_en = 1'b0;
		rd_addr = head_q;
		wr_en = 1'b0;
		wr_addr = head_q;
		wr_data = val_q;
		if (cmd.start) begin
			rd_en = 1'b1;
			unique case (kind_q)
				deq_pkg::K_POP_TAIL, deq_pkg::K_PEEK_TAIL:
					rd_addr = slot(head_q, count_q - CW'(1));
				deq_pkg::K_PEEK_NTH:
					rd_addr = slot(head_q, CW'(pos_q));
				default: rd_addr = head_q;
			endcase
			if (!full && kind_q == deq_pkg::K_PUSH_HEAD) begin
				wr_en = 1'b1;
				wr_addr = head_m1;
			end else if (!full && kind_q == deq_pkg::K_PUSH_TAIL) begin
				wr_en = 1'b1;
				wr_addr = slot(head_q, count_q);
			end
			if (is_rem) rd_addr = head_q;
		end
		if (cmd.walk_rd) begin
			rd_en = 1'b1;
			rd_addr = slot(head_q, rd_q);
		end
		if (cmd.walk_wr && pend_q && !take) begin
			wr_en = 1'b1;
			wr_addr = slot(head_q, wr_q);
			wr_data = rdata_q;
		end
	end

	// status decided when the request is decoded
	always_comb begin
		st_start = deq_pkg::ST_OK;
		unique case (kind_q)
			deq_pkg::K_PUSH_HEAD, deq_pkg::K_PUSH_TAIL:
				if (full) st_start = deq_pkg::ST_FULL;
			deq_pkg::K_POP_HEAD, deq_pkg::K_POP_TAIL,
			deq_pkg::K_PEEK_HEAD, deq_pkg::K_PEEK_TAIL:
				if (empty) st_start = deq_pkg::ST_EMPTY;
			deq_pkg::K_PEEK_NTH:
				if (XW'(pos_q) >= XW'(count_q)) st_start = deq_pkg::ST_RANGE;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			val_q <= value[DATA_WIDTH-1:0];
			pos_q <= position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			rem_q <= '0;
			pend_q <= 1'b0;
			st_pre_q <= deq_pkg::ST_OK;
		end else begin
			if (cmd.start) begin
				st_pre_q <= st_start;
				unique case (kind_q)
					deq_pkg::K_PUSH_HEAD: begin
						if (!full) begin
							head_q <= head_m1;
							count_q <= count_q + CW'(1);
						end
					end
					deq_pkg::K_PUSH_TAIL: begin
						if (!full) count_q <= count_q + CW'(1);
					end
					default: ;
				endcase
				rd_q <= CW'(1);
				wr_q <= '0;
				rem_q <= '0;
				pend_q <= is_rem && !empty;
			end
			if (cmd.finish) begin
				if (st_pre_q == deq_pkg::ST_OK) begin
					unique case (kind_q)
						deq_pkg::K_POP_HEAD: begin
							head_q <= head_p1;
							count_q <= count_q - CW'(1);
						end
						deq_pkg::K_POP_TAIL: count_q <= count_q - CW'(1);
						deq_pkg::K_CLEAR: begin
							head_q <= '0;
							count_q <= '0;
						end
						default: ;
					endcase
				end
			end
			if (cmd.walk_wr) begin
				if (pend_q) begin
					if (take) rem_q <= rem_q + CW'(1);
					else wr_q <= wr_q + CW'(1);
				end
				pend_q <= cmd.walk_rd;
				if (cmd.walk_rd) rd_q <= rd_q + CW'(1);
			end
			if (cmd.walk_end) count_q <= wr_q;
		end
	end

	// result fields for the request that completes
	always_comb begin
		res_st = st_pre_q;
		res_dat = '0;
		res_remc = '0;
		res_fill = OW'(count_q);
		if (cmd.walk_end) begin
			res_st = (rem_q == '0) ? deq_pkg::ST_EMPTY : deq_pkg::ST_OK;
			res_remc = OW'(rem_q);
			res_fill = OW'(wr_q);
		end else if (st_pre_q == deq_pkg::ST_OK) begin
			unique case (kind_q)
				deq_pkg::K_POP_HEAD, deq_pkg::K_POP_TAIL: begin
					res_dat = deq_pkg::VALUE_W'(rdata_q);
					res_fill = OW'(count_q - CW'(1));
				end
				deq_pkg::K_PEEK_HEAD, deq_pkg::K_PEEK_TAIL, deq_pkg::K_PEEK_NTH:
					res_dat = deq_pkg::VALUE_W'(rdata_q);
				deq_pkg::K_CLEAR: res_fill = '0;
				default: ;
			endcase
		end
	end

	// result register, loaded as the request completes
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			st_q <= res_st;
			dat_q <= res_dat;
			remc_q <= res_remc;
			fill_q <= res_fill;
		end
	end

	assign status = st_q;
	assign data_out = dat_q;
	assign removed_count = remc_q;
	assign fill_level = fill_q;

	`DEQ_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`DEQ_ASSERT_IMP(a_wr_le_rd, clk, arst_n, cmd.walk_wr, wr_q < rd_q || !pend_q || wr_q <= rd_q)
	`DEQ_ASSERT_IMP(a_full_refuse, clk, arst_n, cmd.start && full, !wr_en)

endmodule

// File: rtl/double_ended_queue.sv
// Bounded deque of DATA_WIDTH-bit handles held in a DEPTH-entry ring memory with
// head pointer and count. One request is handled at a time: push, pop, peek,
// peek nth and clear latch the request, decode it and issue the memory read,
// then load their result from the registered read of the single-port-read
// memory once the output register is free; remove first and remove all walk
// every entry held before the request through the memory, one per cycle (the
// walk step still runs when the deque is empty). A result waits in an output
// register; the next request is taken once the previous result is loaded, and
// a result not yet taken stalls the next one from loading. No clearing pass
// after reset.
// depends on deq_pkg, deq_if, deq_ctrl, deq_dp
`timescale 1ns / 1ps
module double_ended_queue #(
	parameter int DEPTH = 64,
	parameter int DATA_WIDTH = 64
) (
	input logic     clk,
	input logic     arst_n,
	deq_req_if.sink req,
	deq_rsp_if.source rsp
);

	deq_pkg::deq_cmd_t cmd;
	deq_pkg::deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.stat(stat),
		.cmd(cmd)
	);

	deq_dp #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.kind(req.kind),
		.value(req.value),
		.position(req.position),
		.status(rsp.status),
		.data_out(rsp.data_out),
		.removed_count(rsp.removed_count),
		.fill_level(rsp.fill_level)
	);

endmodule

// File: verif/double_ended_queue_tb.sv
// self-checking testbench for the bounded deque: directed corner cases, then random traffic
// depends on deq_pkg, deq_if and double_ended_queue
`timescale 1ns / 1ps
module double_ended_queue_tb;

	localparam int DEPTH = 64;
	localparam int RANDOM_ITEMS = 800;
	localparam int STALL_LIMIT = 3000;
	localparam int KW = deq_pkg::KIND_W;
	localparam int VW = deq_pkg::VALUE_W;
	localparam int PW = deq_pkg::POS_W;
	localparam int SW = deq_pkg::STATUS_W;
	localparam int CNW = deq_pkg::COUNT_W;

	typedef struct {
		deq_pkg::status_t status;
		logic [VW-1:0] data_out;
		logic [CNW-1:0] removed_count;
		logic [CNW-1:0] fill_level;
	} deq_result_t;

	// tracks deque contents and the results each request should produce
	class deque_scoreboard;
		logic [VW-1:0] slots [DEPTH];
		int unsigned head;
		int unsigned fill;
		deq_result_t awaited [$];
		int unsigned errors;

		function new();
			head = 0;
			fill = 0;
			errors = 0;
		endfunction

		function automatic logic [VW-1:0] entry(int unsigned idx);
			return slots[(head + idx) % DEPTH];
		endfunction

		function automatic int unsigned drop_matches(logic [VW-1:0] key, bit only_first);
			logic [VW-1:0] kept [$];
			int unsigned removed;
			removed = 0;
			for (int unsigned i = 0; i < fill; i++) begin
				if (entry(i) == key && !(only_first && removed > 0))
					removed++;
				else
					kept.push_back(entry(i));
			end
			foreach (kept[i])
				slots[(head + i) % DEPTH] = kept[i];
			fill = kept.size();
			return removed;
		endfunction

		function automatic void note_request(logic [KW-1:0] kind, logic [VW-1:0] value,
				logic [PW-1:0] position);
			deq_result_t r;
			r.status = deq_pkg::ST_OK;
			r.data_out = '0;
			r.removed_count = '0;
			case (kind)
				deq_pkg::K_PUSH_HEAD, deq_pkg::K_PUSH_TAIL: begin
					if (fill >= DEPTH) begin
						r.status = deq_pkg::ST_FULL;
					end else if (kind == deq_pkg::K_PUSH_HEAD) begin
						head = (head + DEPTH - 1) % DEPTH;
						slots[head] = value;
						fill++;
					end else begin
						slots[(head + fill) % DEPTH] = value;
						fill++;
					end
				end
				deq_pkg::K_POP_HEAD, deq_pkg::K_POP_TAIL,
				deq_pkg::K_PEEK_HEAD, deq_pkg::K_PEEK_TAIL: begin
					if (fill == 0) begin
						r.status = deq_pkg::ST_EMPTY;
					end else if (kind == deq_pkg::K_POP_HEAD || kind == deq_pkg::K_PEEK_HEAD) begin
						r.data_out = slots[head];
						if (kind == deq_pkg::K_POP_HEAD) begin
							head = (head + 1) % DEPTH;
							fill--;
						end
					end else begin
						r.data_out = entry(fill - 1);
						if (kind == deq_pkg::K_POP_TAIL)
							fill--;
					end
				end
				deq_pkg::K_PEEK_NTH: begin
					if (position >= fill)
						r.status = deq_pkg::ST_RANGE;
					else
						r.data_out = entry(position);
				end
				deq_pkg::K_REM_FIRST, deq_pkg::K_REM_ALL: begin
					r.removed_count = CNW'(drop_matches(value, kind == deq_pkg::K_REM_FIRST));
					if (r.removed_count == 0)
						r.status = deq_pkg::ST_EMPTY;
				end
				deq_pkg::K_CLEAR: begin
					head = 0;
					fill = 0;
				end
				default: ;
			endcase
			r.fill_level = CNW'(fill);
			awaited.push_back(r);
		endfunction

		function automatic void check_result(logic [SW-1:0] status,
				logic [VW-1:0] data_out, logic [CNW-1:0] removed_count,
				logic [CNW-1:0] fill_level);
			deq_result_t e;
			if (awaited.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (status !== e.status) begin
				$error("status expected %0d actual %0d", e.status, status);
				errors++;
			end
			if (data_out !== e.data_out) begin
				$error("data_out expected %h actual %h", e.data_out, data_out);
				errors++;
			end
			if (removed_count !== e.removed_count) begin
				$error("removed_count expected %0d actual %0d", e.removed_count, removed_count);
				errors++;
			end
			if (fill_level !== e.fill_level) begin
				$error("fill_level expected %0d actual %0d", e.fill_level, fill_level);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();
	deque_scoreboard sb;
	bit steady_mode;
	int unsigned idle_cycles = 0;
	logic [VW-1:0] value_pool [8];

	double_ended_queue u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// mostly no gap, some short ones, a few long ones, none while steady
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady_mode || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(logic [KW-1:0] kind, logic [VW-1:0] value,
			logic [PW-1:0] position);
		int unsigned gap;
		req_ch.valid = 1'b1;
		req_ch.kind = kind;
		req_ch.value = value;
		req_ch.position = position;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(kind, value, position);
		@(negedge clk);
		gap = gap_len();
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		req_ch.valid = 1'b0;
		while (sb.awaited.size() != 0)
			@(negedge clk);
		repeat (DEPTH + 10) @(negedge clk);
	endtask

	function automatic logic [VW-1:0] pick_value();
		if ($urandom_range(0, 9) < 7)
			return value_pool[$urandom_range(0, 7)];
		return {$urandom, $urandom};
	endfunction

	// result side: random backpressure
	initial begin
		int unsigned gap;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rsp_ch.ready = 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			gap = gap_len();
			if (gap > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.status, rsp_ch.data_out, rsp_ch.removed_count,
				rsp_ch.fill_level);
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned target;
		int unsigned r;
		logic [KW-1:0] k;
		sb = new();
		steady_mode = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = '0;
		req_ch.value = '0;
		req_ch.position = '0;
		value_pool[0] = '0;
		value_pool[1] = '1;
		value_pool[2] = 64'h5555_5555_5555_5555;
		value_pool[3] = 64'hAAAA_AAAA_AAAA_AAAA;
		for (int i = 4; i < 8; i++)
			value_pool[i] = {$urandom, $urandom};
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty queue corners, then the unused request kinds
		send(deq_pkg::K_POP_HEAD, '0, '0);
		send(deq_pkg::K_POP_TAIL, '0, '0);
		send(deq_pkg::K_PEEK_HEAD, '0, '0);
		send(deq_pkg::K_PEEK_TAIL, '0, '0);
		send(deq_pkg::K_PEEK_NTH, '0, '0);
		send(deq_pkg::K_REM_FIRST, '1, '0);
		send(deq_pkg::K_REM_ALL, '1, '0);
		send(deq_pkg::K_CLEAR, '0, '0);
		for (int k2 = 10; k2 < 16; k2++)
			send(k2[KW-1:0], '1, '1);
		// small contents with duplicates
		send(deq_pkg::K_PUSH_TAIL, '1, '0);
		send(deq_pkg::K_PUSH_HEAD, '0, '0);
		send(deq_pkg::K_PUSH_TAIL, '1, '0);
		send(deq_pkg::K_PUSH_HEAD, 64'h5555_5555_5555_5555, '0);
		send(deq_pkg::K_PEEK_NTH, '0, 6'd3);
		send(deq_pkg::K_PEEK_NTH, '0, 6'd4);
		send(deq_pkg::K_PEEK_NTH, '0, '1);
		send(deq_pkg::K_PEEK_HEAD, '0, '0);
		send(deq_pkg::K_PEEK_TAIL, '0, '0);
		send(deq_pkg::K_REM_FIRST, 64'h1234, '0);
		send(deq_pkg::K_REM_FIRST, '1, '0);
		send(deq_pkg::K_PUSH_TAIL, '1, '0);
		send(deq_pkg::K_PUSH_TAIL, '1, '0);
		send(deq_pkg::K_REM_ALL, '1, '0);
		send(deq_pkg::K_POP_TAIL, '0, '0);
		send(deq_pkg::K_POP_HEAD, '0, '0);
		// fill to capacity, wrapping the ring, then refuse pushes, peek the last entry, pop and clear
		for (int i = 0; i < DEPTH; i++)
			send(i[0] ? deq_pkg::K_PUSH_HEAD : deq_pkg::K_PUSH_TAIL, {$urandom, $urandom}, '0);
		send(deq_pkg::K_PUSH_HEAD, '1, '0);
		send(deq_pkg::K_PUSH_TAIL, '1, '0);
		send(deq_pkg::K_PEEK_NTH, '0, 6'd63);
		send(deq_pkg::K_POP_TAIL, '0, '0);
		send(deq_pkg::K_CLEAR, '0, '0);

		// random phases alternating between growing and shrinking the fill
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0) begin
				target = (n / 150) % 2 ? $urandom_range(0, 8) : $urandom_range(40, DEPTH + 4);
				steady_mode = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 3)
				k = KW'($urandom_range(10, 15));
			else if (r < 5)
				k = deq_pkg::K_CLEAR;
			else if (r < 45)
				k = (sb.fill < target)
					? KW'($urandom_range(deq_pkg::K_PUSH_HEAD, deq_pkg::K_PUSH_TAIL))
					: KW'($urandom_range(deq_pkg::K_POP_HEAD, deq_pkg::K_POP_TAIL));
			else if (r < 55)
				k = KW'($urandom_range(deq_pkg::K_PUSH_HEAD, deq_pkg::K_PUSH_TAIL));
			else
				k = KW'($urandom_range(deq_pkg::K_POP_HEAD, deq_pkg::K_REM_ALL));
			send(k, pick_value(), PW'($urandom_range(0, 63)));
		end
		drain();
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
